// ===== design/sip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sip_pkg: shared types and constants for the SipHash-2-4 block
// Lane type, controller-to-datapath command, initialization constants and
// the SipRound function.
// ----------------------------------------------------------------------------
package sip_pkg;

  localparam int unsigned LaneW = 64;

  typedef logic [LaneW-1:0] lane_t;
  typedef logic [3:0][LaneW-1:0] lanes_t;

  localparam lane_t SIP_C0 = 64'h736f6d6570736575;
  localparam lane_t SIP_C1 = 64'h646f72616e646f6d;
  localparam lane_t SIP_C2 = 64'h6c7967656e657261;
  localparam lane_t SIP_C3 = 64'h7465646279746573;
  localparam lane_t SIP_FIN = 64'h00000000000000ff;
  localparam int unsigned LenShift = 56;

  // Configuration register indexes
  localparam logic REG_KEY_LOW = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  // Datapath command
  typedef struct packed {
    logic absorb;  // take the input word and run the first round
    logic fold;    // second round of compression, then xor word into v0
    logic finish;  // with fold: xor 0xff into v2
    logic round;   // plain finalization round
    logic emit;    // load the tag register
  } cmd_t;

  function automatic lane_t rotl(input lane_t x, input int unsigned r);
    rotl = (x << r) | (x >> (LaneW - r));
  endfunction

  function automatic lanes_t sip_round(input lanes_t v);
    lane_t a, b, c, d;
    a = v[0];
    b = v[1];
    c = v[2];
    d = v[3];
    a = a + b; b = rotl(b, 13); b = b ^ a; a = rotl(a, 32);
    c = c + d; d = rotl(d, 16); d = d ^ c;
    a = a + d; d = rotl(d, 21); d = d ^ a;
    c = c + b; b = rotl(b, 17); b = b ^ c; c = rotl(c, 32);
    sip_round = {d, c, b, a};
  endfunction

  // Keep the low tail bytes of the word
  function automatic logic [LenShift-1:0] tail_mask(input logic [2:0] tail);
    logic [LenShift-1:0] m;
    m = '0;
    for (int i = 0; i < 7; i++) begin
      if (3'(i) < tail) m[8*i +: 8] = 8'hff;
    end
    tail_mask = m;
  endfunction

endpackage

// ===== design/sip_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sip_ctrl: SipHash sequencer
// Steps the datapath through compression and finalization rounds and
// handles the input and output handshakes.
// ----------------------------------------------------------------------------
module sip_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          last_word,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output sip_pkg::cmd_t cmd
);
  import sip_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_COMP = 4'b0010,
    S_FIN  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [1:0] fin_count, fin_count_next;
  logic last_q, last_q_next;
  logic out_free;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    fin_count_next = fin_count;
    last_q_next = last_q;
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.absorb = 1'b1;
          last_q_next = last_word;
          state_next = S_COMP;
        end
      end
      S_COMP: begin
        cmd.fold = 1'b1;
        cmd.finish = last_q;
        fin_count_next = '0;
        state_next = last_q ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        cmd.round = 1'b1;
        fin_count_next = fin_count + 2'd1;
        if (fin_count == 2'd3) state_next = S_EMIT;
      end
      S_EMIT: begin
        // hold the tag until the output register frees up
        if (out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fin_count <= '0;
      last_q <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fin_count <= fin_count_next;
      last_q <= last_q_next;
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

endmodule

// ===== design/sip_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sip_dp: SipHash datapath
// Key registers, four hash lanes with one SipRound unit, message length
// counter and tag register.
// ----------------------------------------------------------------------------
module sip_dp (
  input  logic          clk,
  input  logic          rst,
  input  sip_pkg::cmd_t cmd,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  sip_pkg::lane_t cfg_data,
  input  sip_pkg::lane_t msg_word,
  input  logic [2:0]    tail_bytes,
  input  logic          last_word,
  output sip_pkg::lane_t mac_tag
);
  import sip_pkg::*;

  lane_t key_low, key_high;
  lanes_t lanes, lanes_next;
  lane_t word_q;
  logic [7:0] length_count;
  logic at_start;

  lanes_t base, rnd_in, rnd_out;
  lane_t packed_word;
  logic [7:0] len_base, len_next;

  always_comb begin
    len_base = at_start ? 8'd0 : length_count;
    len_next = last_word ? (len_base + {5'd0, tail_bytes}) : (len_base + 8'd8);
    packed_word = last_word
                ? {len_base + {5'd0, tail_bytes}, msg_word[LenShift-1:0] & tail_mask(tail_bytes)}
                : msg_word;

    // new message: load lanes from key
    if (at_start) base = {key_high ^ SIP_C3, key_low ^ SIP_C2, key_high ^ SIP_C1,
                          key_low ^ SIP_C0};
    else base = lanes;

    rnd_in = lanes;
    if (cmd.absorb) begin
      rnd_in = base;
      rnd_in[3] = base[3] ^ packed_word;
    end
    rnd_out = sip_round(rnd_in);

    lanes_next = rnd_out;
    if (cmd.fold) lanes_next[0] = rnd_out[0] ^ word_q;
    if (cmd.finish) lanes_next[2] = rnd_out[2] ^ SIP_FIN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low <= '0;
      key_high <= '0;
      length_count <= '0;
      at_start <= 1'b1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KEY_LOW:  key_low <= cfg_data;
          REG_KEY_HIGH: key_high <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.absorb) begin
        length_count <= len_next;
        at_start <= last_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.absorb) word_q <= packed_word;
    if (cmd.absorb || cmd.fold || cmd.round) lanes <= lanes_next;
    if (cmd.emit) mac_tag <= lanes[0] ^ lanes[1] ^ lanes[2] ^ lanes[3];
  end

endmodule

// ===== design/siphash_2_4_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siphash_2_4_mac: keyed SipHash-2-4 tag generator
// Hashes a message given as 64-bit little-endian words and returns the tag.
//
//  channel  signals                                   direction
//  -------  ----------------------------------------  ---------
//  cfg      cfg_valid/cfg_ready, cfg_index, cfg_data  in
//  in       in_valid/in_stall, msg_word, tail_bytes,  in
//           last_word
//  out      out_valid/out_stall, mac_tag              out
//
// A full word runs 2 SipRounds (one SipRound per cycle in a single round unit).
// The last word runs 2 compression rounds and 4 finalization rounds, then loads
// the tag register, later if that register is still held.
// Reset clears the key registers to zero and drops any partial message.
// The input is stalled while rounds run and while a new tag waits on a held tag.
// ----------------------------------------------------------------------------
module siphash_2_4_mac (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_index,
  input  sip_pkg::lane_t cfg_data,
  input  logic           in_valid,
  output logic           in_stall,
  input  sip_pkg::lane_t msg_word,
  input  logic [2:0]     tail_bytes,
  input  logic           last_word,
  output logic           out_valid,
  input  logic           out_stall,
  output sip_pkg::lane_t mac_tag
);
  import sip_pkg::*;

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  sip_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_word (last_word),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  sip_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .msg_word   (msg_word),
    .tail_bytes (tail_bytes),
    .last_word  (last_word),
    .mac_tag    (mac_tag)
  );

`ifndef SYNTHESIS
  // a full word returns to idle after its two rounds
  a_word_cycles: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !last_word |-> ##2 !in_stall)
    else $error("full word did not finish in two cycles");

  // finalization keeps the input stalled
  a_final_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_word |-> ##6 in_stall)
    else $error("input accepted during finalization");

  // a new tag only appears at the end of a busy period
  a_tag_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("tag appeared without finalization");
`endif

endmodule
